// ===== hdl/lsb_stego_embed_walk_assert.svh =====
// Assertion macros shared by the embedder modules.
// LSEW_ASSERT_IMP checks that cons holds in the same cycle as ante.
// LSEW_ASSERT_NXT checks that cons holds in the cycle after ante.
`ifndef LSB_STEGO_EMBED_WALK_ASSERT_SVH
`define LSB_STEGO_EMBED_WALK_ASSERT_SVH
`ifndef SYNTHESIS
`define LSEW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsew assertion failed");
`define LSEW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsew assertion failed");
`else
`define LSEW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSEW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lsew_pkg.sv =====
`default_nettype none
package lsew_pkg;

  localparam int DIM_W    = 13;  // image width / height registers
  localparam int COL_W    = 12;  // walk column
  localparam int ROW_W    = 13;  // walk row
  localparam int JUMP_W   = 12;
  localparam int DEPTH_W  = 4;
  localparam int CFG_W    = 13;
  localparam int WORK_W   = 15;  // walk arithmetic before wrapping
  localparam int PEND_W   = 31;  // queued message bits
  localparam int PCNT_W   = 5;
  localparam int PIX_W    = 24;  // three channels of up to eight bits
  localparam int PCOUNT_W = 25;  // pixels written, saturating
  localparam int CAP_W    = 26;  // width times height
  localparam int RES_W    = 3;
  localparam int DIV_STEPS = WORK_W;
  localparam int DCNT_W   = 4;

  localparam logic [RES_W-1:0] RESULTS_MAX = 3'd4;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_WALK_JUMP,
    REG_BITS_PER_CHANNEL
  } lsew_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WROW,
    ST_WDIV1,
    ST_WCOL,
    ST_WDIV2,
    ST_WFIX
  } lsew_state_t;

  typedef struct packed {
    logic load;        // take the accepted byte into the bit queue
    logic cfg_we;      // write a configuration register
    logic emit;        // capture one pixel write into the output register
    logic partial;     // the captured pixel is the zero-padded flush
    logic run_end;     // the captured pixel is the last one of this byte
    logic div_start;   // start a wrap division
    logic div_col;     // divide the column by the width (else row by height)
    logic take_row;    // fold the row division result into the walk
    logic take_col;    // fold the column division result into the walk
    logic commit;      // write the stepped walk position back
    logic clear_pend;  // drop queued bits at the end of a message
  } lsew_cmd_t;

  typedef struct packed {
    logic pc_ge_n;     // a whole pixel of bits is queued
    logic pc_nz;       // some bits are queued
    logic final_flag;  // current byte ends the message
    logic more_after;  // a whole pixel stays queued after this one
    logic rest_after;  // bits stay queued after this one
    logic slot_free;   // output register can take a pixel this cycle
    logic row_ovf;     // stepped row is past the last row
    logic col_ovf;     // carried column is past the last column
    logic div_done;
  } lsew_stat_t;

endpackage
`default_nettype wire

// ===== hdl/lsew_div.sv =====
`default_nettype none
`include "lsb_stego_embed_walk_assert.svh"
module lsew_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lsew_pkg::WORK_W-1:0] dividend,
  input  wire logic [lsew_pkg::DIM_W-1:0]  divisor,
  output logic      [lsew_pkg::WORK_W-1:0] quotient,
  output logic      [lsew_pkg::DIM_W-1:0]  remainder,
  output logic                             done
);
  import lsew_pkg::*;

  logic [WORK_W-1:0] quo_r;
  logic [DIM_W-1:0]  rem_r;
  logic [DIM_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIM_W:0]    trial;
  logic [DIM_W:0]    diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, quo_r[WORK_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[WORK_W-2:0], fits};
      rem_r <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

  `LSEW_ASSERT_NXT(a_div_busy_after_start, clk, rst_n, start, busy_r && !done_r)
  `LSEW_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_r, !busy_r)

endmodule
`default_nettype wire

// ===== hdl/lsew_dpath.sv =====
`default_nettype none
module lsew_dpath #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lsew_pkg::lsew_cmd_t           cmd,
  output lsew_pkg::lsew_stat_t               st,
  input  wire logic [7:0]                    in_message_byte,
  input  wire logic                          in_final_byte,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [lsew_pkg::CFG_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lsew_pkg::COL_W-1:0]    out_pixel_col,
  output logic      [lsew_pkg::ROW_W-1:0]    out_pixel_row,
  output logic      [7:0]                    out_red_low,
  output logic      [7:0]                    out_green_low,
  output logic      [7:0]                    out_blue_low,
  output logic      [1:0]                    out_channels_used,
  output logic                               out_run_end,
  output logic                               out_capacity_exceeded
);
  import lsew_pkg::*;

  localparam logic [DIM_W-1:0] DIM_LIMIT =
    (MAX_DIM > 8191) ? 13'd8191 : DIM_W'(MAX_DIM);

  // Configuration, held in effective (clamped) form.
  logic [DIM_W-1:0]   wd_r, ht_r;
  logic [JUMP_W-1:0]  jump_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [CAP_W-1:0]   cap_r;
  logic [DIM_W-1:0]   dim_clamped;
  logic [DEPTH_W-1:0] depth_clamped;

  // Message and walk state.
  logic [PEND_W-1:0]   pend_bits_r;
  logic [PCNT_W-1:0]   pend_cnt_r;
  logic                final_r;
  logic [COL_W-1:0]    walk_col_r;
  logic [ROW_W-1:0]    walk_row_r;
  logic [PCOUNT_W-1:0] pix_cnt_r;
  logic [WORK_W-1:0]   wc_r, wr_r;

  // Output register.
  logic               out_valid_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [7:0]         red_r, green_r, blue_r;
  logic [1:0]         used_r;
  logic               run_end_r;
  logic               drop_r;

  // Pixel extraction.
  logic [PCNT_W-1:0] n_bits;
  logic [PCNT_W-1:0] pc_rest;
  logic [PIX_W-1:0]  nmask;
  logic [PIX_W-1:0]  full_pix, part_pix, pix;
  logic [7:0]        cmask;
  logic [7:0]        red_v, green_v, blue_v;
  logic [1:0]        used;
  logic              drop;
  logic [PEND_W-1:0] rest_mask;

  // Walk arithmetic.
  logic [WORK_W-1:0] div_q;
  logic [DIM_W-1:0]  div_rem;
  logic              div_done;
  logic [WORK_W-1:0] row_final;

  always_comb begin
    dim_clamped = cfg_data;
    if (cfg_data == '0) begin
      dim_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_LIMIT) begin
      dim_clamped = DIM_LIMIT;
    end
    depth_clamped = cfg_data[DEPTH_W-1:0];
    if (cfg_data[DEPTH_W-1:0] == '0) begin
      depth_clamped = DEPTH_W'(1);
    end else if (cfg_data[DEPTH_W-1:0] > DEPTH_W'(8)) begin
      depth_clamped = DEPTH_W'(8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r    <= DIM_W'(1);
      ht_r    <= DIM_W'(1);
      jump_r  <= JUMP_W'(1);
      depth_r <= DEPTH_W'(1);
    end else if (cmd.cfg_we) begin
      unique case (lsew_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:      wd_r    <= dim_clamped;
        REG_IMAGE_HEIGHT:     ht_r    <= dim_clamped;
        REG_WALK_JUMP:        jump_r  <= cfg_data[JUMP_W-1:0];
        REG_BITS_PER_CHANNEL: depth_r <= depth_clamped;
        default:              ;
      endcase
    end
  end

  // Image capacity follows the registers in the cycle after they change.
  always_ff @(posedge clk) begin
    cap_r <= CAP_W'(wd_r * ht_r);
  end

  assign n_bits    = PCNT_W'({depth_r, 1'b0} + {1'b0, depth_r});
  assign pc_rest   = pend_cnt_r - n_bits;
  assign nmask     = PIX_W'((25'd1 << n_bits) - 25'd1);
  assign cmask     = 8'((9'd1 << depth_r) - 9'd1);
  assign rest_mask = (PEND_W'(1) << pc_rest) - PEND_W'(1);
  assign full_pix  = PIX_W'(pend_bits_r >> pc_rest) & nmask;
  assign part_pix  = PIX_W'(pend_bits_r << (n_bits - pend_cnt_r)) & nmask;
  assign pix       = cmd.partial ? part_pix : full_pix;

  // A flushed pixel fills only the channels that its bits reach.
  always_comb begin
    used = 2'd3;
    if (cmd.partial) begin
      if (pend_cnt_r > {depth_r, 1'b0}) begin
        used = 2'd3;
      end else if (pend_cnt_r > {1'b0, depth_r}) begin
        used = 2'd2;
      end else begin
        used = 2'd1;
      end
    end
    red_v   = 8'(pix >> {depth_r, 1'b0}) & cmask;
    green_v = (used >= 2'd2) ? (8'(pix >> depth_r) & cmask) : 8'd0;
    blue_v  = (used == 2'd3) ? (8'(pix) & cmask) : 8'd0;
  end

  assign drop = ({1'b0, pix_cnt_r} >= cap_r) || ({1'b0, walk_col_r} >= wd_r) ||
                (walk_row_r >= ht_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      final_r     <= 1'b0;
    end else if (cmd.cfg_we && (lsew_reg_t'(cfg_index) == REG_BITS_PER_CHANNEL)) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (cmd.load) begin
      pend_bits_r <= {pend_bits_r[PEND_W-9:0], in_message_byte};
      pend_cnt_r  <= pend_cnt_r + PCNT_W'(8);
      final_r     <= in_final_byte;
    end else if (cmd.emit) begin
      if (cmd.partial) begin
        pend_bits_r <= '0;
        pend_cnt_r  <= '0;
      end else begin
        pend_bits_r <= pend_bits_r & rest_mask;
        pend_cnt_r  <= pc_rest;
      end
    end else if (cmd.clear_pend) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end
  end

  lsew_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (cmd.div_col ? wc_r : wr_r),
    .divisor   (cmd.div_col ? wd_r : ht_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .done      (div_done)
  );

  // A walk that comes back to the origin skips on by half a jump.
  assign row_final = ((wc_r == '0) && (wr_r == '0)) ?
                     (wr_r + WORK_W'(jump_r >> 1)) : wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_col_r <= '0;
      walk_row_r <= '0;
      pix_cnt_r  <= '0;
    end else begin
      if (cmd.emit && (pix_cnt_r != '1)) begin
        pix_cnt_r <= pix_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        walk_col_r <= wc_r[COL_W-1:0];
        walk_row_r <= row_final[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      wr_r <= WORK_W'(walk_row_r) + WORK_W'(jump_r);
      wc_r <= WORK_W'(walk_col_r);
    end else if (cmd.take_row) begin
      wc_r <= wc_r + div_q;
      wr_r <= WORK_W'(div_rem);
    end else if (cmd.take_col) begin
      wr_r <= wr_r + div_q;
      wc_r <= WORK_W'(div_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      col_r     <= walk_col_r;
      row_r     <= walk_row_r;
      red_r     <= red_v;
      green_r   <= green_v;
      blue_r    <= blue_v;
      used_r    <= used;
      run_end_r <= cmd.run_end;
      drop_r    <= drop;
    end
  end

  assign st.pc_ge_n    = pend_cnt_r >= n_bits;
  assign st.pc_nz      = pend_cnt_r != '0;
  assign st.final_flag = final_r;
  assign st.more_after = pc_rest >= n_bits;
  assign st.rest_after = pc_rest != '0;
  assign st.slot_free  = !out_valid_r || out_ready;
  assign st.row_ovf    = wr_r >= WORK_W'(ht_r);
  assign st.col_ovf    = wc_r >= WORK_W'(wd_r);
  assign st.div_done   = div_done;

  assign out_valid             = out_valid_r;
  assign out_pixel_col         = col_r;
  assign out_pixel_row         = row_r;
  assign out_red_low           = red_r;
  assign out_green_low         = green_r;
  assign out_blue_low          = blue_r;
  assign out_channels_used     = used_r;
  assign out_run_end           = run_end_r;
  assign out_capacity_exceeded = drop_r;

endmodule
`default_nettype wire

// ===== hdl/lsew_ctrl.sv =====
`default_nettype none
`include "lsb_stego_embed_walk_assert.svh"
module lsew_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire lsew_pkg::lsew_stat_t st,
  output lsew_pkg::lsew_cmd_t       cmd
);
  import lsew_pkg::*;

  lsew_state_t      state_r, state_nxt;
  logic [RES_W-1:0] cnt_r;
  logic             room;
  logic             full_ok;
  logic             part_ok;
  logic             more;

  // At most four pixel writes come from one byte.
  assign room    = cnt_r < RESULTS_MAX;
  assign full_ok = room && st.pc_ge_n;
  assign part_ok = room && !st.pc_ge_n && st.final_flag && st.pc_nz;
  assign more    = (cnt_r < (RESULTS_MAX - 1'b1)) &&
                   (st.more_after || (st.final_flag && st.rest_after));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (full_ok || part_ok) begin
          if (st.slot_free) begin
            state_nxt = ST_WROW;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WROW:  state_nxt = st.row_ovf ? ST_WDIV1 : ST_WFIX;
      ST_WDIV1: state_nxt = st.div_done ? ST_WCOL : ST_WDIV1;
      ST_WCOL:  state_nxt = st.col_ovf ? ST_WDIV2 : ST_WFIX;
      ST_WDIV2: state_nxt = st.div_done ? ST_WFIX : ST_WDIV2;
      ST_WFIX:  state_nxt = ST_CHECK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = !cfg_valid;
        cfg_ready  = 1'b1;
        cmd.load   = in_valid && !cfg_valid;
        cmd.cfg_we = cfg_valid;
      end
      ST_CHECK: begin
        if (full_ok || part_ok) begin
          cmd.emit    = st.slot_free;
          cmd.partial = part_ok;
          cmd.run_end = part_ok || !more;
        end else begin
          cmd.clear_pend = st.final_flag;
        end
      end
      ST_WROW: begin
        cmd.div_start = st.row_ovf;
      end
      ST_WDIV1: begin
        cmd.take_row = st.div_done;
      end
      ST_WCOL: begin
        cmd.div_start = st.col_ovf;
        cmd.div_col   = 1'b1;
      end
      ST_WDIV2: begin
        cmd.take_col = st.div_done;
        cmd.div_col  = 1'b1;
      end
      ST_WFIX: begin
        cmd.commit = 1'b1;
      end
      default: ;
    endcase
  end

  `LSEW_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, st.slot_free)
  `LSEW_ASSERT_IMP(a_result_limit, clk, rst_n, 1'b1, cnt_r <= RESULTS_MAX)
  `LSEW_ASSERT_NXT(a_wait_divider, clk, rst_n, (state_r == ST_WDIV1) && !st.div_done, state_r == ST_WDIV1)
  `LSEW_ASSERT_NXT(a_emit_walks, clk, rst_n, cmd.emit, state_r == ST_WROW)

endmodule
`default_nettype wire

// ===== hdl/lsb_stego_embed_walk.sv =====
`default_nettype none
// LSB steganography embedder. Message bytes arrive MSB first on the in_ channel; every
// 3*bits_per_channel queued bits leave as one pixel write on the out_ channel, with red,
// green and blue low bits right aligned and the pixel's column and row from a strided walk
// that wraps rows into columns and back. A byte marked final flushes a zero-padded partial
// pixel. After each pixel write the walk steps its row; a row that leaves the image is
// wrapped into the column by the single shared divider, which produces one quotient bit per
// cycle; the divider then wraps the column too if it leaves the image. A byte gives at
// most four pixel writes. The next byte is taken while the last pixel write is still
// waiting on out_ready. Configuration is written only while the block is idle; writing
// bits_per_channel discards any queued message bits.
module lsb_stego_embed_walk #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_message_byte,
  input  wire logic                       in_final_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [lsew_pkg::COL_W-1:0] out_pixel_col,
  output logic      [lsew_pkg::ROW_W-1:0] out_pixel_row,
  output logic      [7:0]                 out_red_low,
  output logic      [7:0]                 out_green_low,
  output logic      [7:0]                 out_blue_low,
  output logic      [1:0]                 out_channels_used,
  output logic                            out_run_end,
  output logic                            out_capacity_exceeded,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [lsew_pkg::CFG_W-1:0] cfg_data
);
  import lsew_pkg::*;

  lsew_cmd_t  cmd;
  lsew_stat_t st;

  lsew_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lsew_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_message_byte       (in_message_byte),
    .in_final_byte         (in_final_byte),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pixel_col         (out_pixel_col),
    .out_pixel_row         (out_pixel_row),
    .out_red_low           (out_red_low),
    .out_green_low         (out_green_low),
    .out_blue_low          (out_blue_low),
    .out_channels_used     (out_channels_used),
    .out_run_end           (out_run_end),
    .out_capacity_exceeded (out_capacity_exceeded)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lsew_pkg::*;

  typedef struct packed {
    logic [11:0] col;
    logic [12:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  used;
    logic        run_end;
    logic        cap;
  } pixel_write_t;

  typedef enum logic { ROW_REG, ROW_BYTE } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    lsew_reg_t    idx;
    logic [12:0]  value;
    logic [7:0]   data;
    logic         fin;
    logic         typed;
    pixel_write_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_pixel_col;
  logic [12:0] out_pixel_row;
  logic [7:0]  out_red_low;
  logic [7:0]  out_green_low;
  logic [7:0]  out_blue_low;
  logic [1:0]  out_channels_used;
  logic        out_run_end;
  logic        out_capacity_exceeded;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  lsew_reg_t   cfg_index = REG_IMAGE_WIDTH;
  logic [12:0] cfg_data = 13'd0;

  // Embedder state as predicted from the accepted transactions.
  logic [12:0] img_w = 13'd1;
  logic [12:0] img_h = 13'd1;
  logic [11:0] jump = 12'd1;
  logic [3:0]  depth_reg = 4'd1;
  int unsigned pend_bits = 0;
  int unsigned pend_cnt = 0;
  logic [11:0] cur_col = 12'd0;
  logic [12:0] cur_row = 13'd0;
  logic [24:0] px_count = 25'd0;

  pixel_write_t pixel_writes_due[$];
  bit failed = 1'b0;
  bit steady = 1'b0;

  stim_row_t directed_rows [0:27] = '{
    '{ROW_REG,  REG_BITS_PER_CHANNEL, 13'd8,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hA5, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h3C, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hFF, 1'b0, 1'b1,
      '{12'd0, 13'd0, 8'hA5, 8'h3C, 8'hFF, 2'd3, 1'b1, 1'b0}},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h80, 1'b1, 1'b1,
      '{12'd0, 13'd1, 8'h80, 8'h00, 8'h00, 2'd1, 1'b1, 1'b1}},
    '{ROW_REG,  REG_IMAGE_WIDTH,      13'd4096, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_IMAGE_HEIGHT,     13'd4096, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_WALK_JUMP,        13'd4095, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_BITS_PER_CHANNEL, 13'd1,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h80, 1'b1, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h01, 1'b1, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h00, 1'b1, 1'b0, '0},
    '{ROW_REG,  REG_BITS_PER_CHANNEL, 13'd15,   8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h55, 1'b1, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hAA, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h0F, 1'b1, 1'b0, '0},
    '{ROW_REG,  REG_IMAGE_WIDTH,      13'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_IMAGE_HEIGHT,     13'd8191, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_WALK_JUMP,        13'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_BITS_PER_CHANNEL, 13'd0,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hC3, 1'b1, 1'b0, '0},
    '{ROW_REG,  REG_IMAGE_WIDTH,      13'd8191, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_WALK_JUMP,        13'd2,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_BITS_PER_CHANNEL, 13'd3,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'hF0, 1'b0, 1'b0, '0},
    '{ROW_BYTE, REG_IMAGE_WIDTH,      13'd0,    8'h0F, 1'b1, 1'b0, '0}
  };

  lsb_stego_embed_walk i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_message_byte       (in_message_byte),
    .in_final_byte         (in_final_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pixel_col         (out_pixel_col),
    .out_pixel_row         (out_pixel_row),
    .out_red_low           (out_red_low),
    .out_green_low         (out_green_low),
    .out_blue_low          (out_blue_low),
    .out_channels_used     (out_channels_used),
    .out_run_end           (out_run_end),
    .out_capacity_exceeded (out_capacity_exceeded),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return int'(v);
  endfunction

  // Packs one pixel at the current walk position, then steps the walk.
  function automatic pixel_write_t walk_pixel(int unsigned pix, int unsigned used,
                                              int unsigned d);
    pixel_write_t p;
    int unsigned w, h, cm, r, c;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    cm = (1 << d) - 1;
    p.col = cur_col;
    p.row = cur_row;
    p.red = (used >= 1) ? 8'((pix >> (2 * d)) & cm) : 8'd0;
    p.green = (used >= 2) ? 8'((pix >> d) & cm) : 8'd0;
    p.blue = (used >= 3) ? 8'(pix & cm) : 8'd0;
    p.used = 2'(used);
    p.run_end = 1'b0;
    p.cap = (int'(px_count) >= w * h) || (int'(cur_col) >= w) || (int'(cur_row) >= h);
    if (px_count != 25'h1FFFFFF) px_count = px_count + 25'd1;
    r = int'(cur_row) + int'(jump);
    c = int'(cur_col);
    if (r >= h) begin
      c = c + r / h;
      r = r % h;
      if (c >= w) begin
        r = r + c / w;
        c = c % w;
      end
    end
    if (c == 0 && r == 0) r = r + int'(jump) / 2;
    cur_col = c[11:0];
    cur_row = r[12:0];
    return p;
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4097, 8191));
      1: return 13'd4096;
      2, 3, 4, 5: return 13'($urandom_range(1, 16));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Register writes happen only while the block is idle.
  task automatic write_reg(lsew_reg_t idx, logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: img_w = value;
      REG_IMAGE_HEIGHT: img_h = value;
      REG_WALK_JUMP: jump = value[11:0];
      REG_BITS_PER_CHANNEL: begin
        depth_reg = value[3:0];
        pend_bits = 0;
        pend_cnt = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Lets every pending pixel write drain, then gives a byte that queues bits
  // without producing a pixel time to settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pixel_writes_due.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  // Sends one byte and, once the transaction is accepted, predicts the
  // pixel writes it causes.
  task automatic send_byte(logic [7:0] b, logic fin, logic typed, pixel_write_t want);
    int unsigned gap, n0, d, n, nmask, pix, used, cnt;
    pixel_write_t held;
    bit have;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_message_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    n0 = pixel_writes_due.size();
    d = (depth_reg == 4'd0) ? 1 : (depth_reg > 4'd8) ? 8 : int'(depth_reg);
    n = 3 * d;
    nmask = (1 << n) - 1;
    cnt = 0;
    have = 1'b0;
    pend_bits = (pend_bits << 8) | int'(b);
    pend_cnt = pend_cnt + 8;
    while (pend_cnt >= n && cnt < 4) begin
      pix = (pend_bits >> (pend_cnt - n)) & nmask;
      if (have) pixel_writes_due.push_back(held);
      held = walk_pixel(pix, 3, d);
      have = 1'b1;
      pend_cnt = pend_cnt - n;
      pend_bits = pend_bits & ((pend_cnt == 0) ? 0 : ((1 << pend_cnt) - 1));
      cnt++;
    end
    if (fin) begin
      // Flush of a partial pixel: started channels are zero-padded.
      if (pend_cnt > 0 && cnt < 4) begin
        pix = (pend_bits << (n - pend_cnt)) & nmask;
        used = (pend_cnt + d - 1) / d;
        if (have) pixel_writes_due.push_back(held);
        held = walk_pixel(pix, used, d);
        have = 1'b1;
        cnt++;
      end
      pend_bits = 0;
      pend_cnt = 0;
    end
    if (have) begin
      held.run_end = 1'b1;
      pixel_writes_due.push_back(held);
    end

    if (typed) begin
      if (pixel_writes_due.size() != n0 + 1) begin
        $error("directed byte %02h: expected one pixel write, predicted %0d", b, cnt);
        failed = 1'b1;
      end else begin
        pixel_writes_due[pixel_writes_due.size() - 1] = want;
      end
    end
    @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned gap;
    @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pixel_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_writes_due.size() == 0) begin
        $error("unexpected pixel write at col %0d row %0d", out_pixel_col, out_pixel_row);
        failed = 1'b1;
      end else begin
        want = pixel_writes_due.pop_front();
        check_field("pixel_col", want.col, out_pixel_col);
        check_field("pixel_row", want.row, out_pixel_row);
        check_field("red_low", want.red, out_red_low);
        check_field("green_low", want.green, out_green_low);
        check_field("blue_low", want.blue, out_blue_low);
        check_field("channels_used", want.used, out_channels_used);
        check_field("run_end", want.run_end, out_run_end);
        check_field("capacity_exceeded", want.cap, out_capacity_exceeded);
      end
    end
  end

  initial begin : main
    int unsigned sent, phase, msgs, len, k, m, i;
    logic [12:0] value;
    logic fin;
    bit broken;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        quiesce();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_byte(directed_rows[r].data, directed_rows[r].fin, directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 210) begin
      quiesce();
      for (k = 0; k < 4; k++) begin
        if (phase == 0 || $urandom_range(0, 1) == 1) begin
          case (lsew_reg_t'(k))
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: value = pick_dim();
            REG_WALK_JUMP: begin
              case ($urandom_range(0, 7))
                0: value = 13'd0;
                1: value = 13'd4095;
                2, 3: value = 13'($urandom_range(1, 8));
                default: value = 13'($urandom_range(1, 4095));
              endcase
              // Bit 12 lies outside the jump register and must be ignored.
              value[12] = 1'($urandom_range(0, 1));
            end
            default: begin
              if ($urandom_range(0, 3) == 0) value = 13'($urandom_range(0, 8191));
              else value = 13'($urandom_range(1, 8));
            end
          endcase
          write_reg(lsew_reg_t'(k), value);
        end
      end

      steady = ($urandom_range(0, 3) == 0);
      msgs = (phase == 0) ? 2 : $urandom_range(1, 4);
      for (m = 0; m < msgs; m++) begin
        if (m == 1 && phase % 3 == 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pixel_writes_due.size() != 0) @(negedge clk);
        end
        len = $urandom_range(1, 10);
        broken = ($urandom_range(0, 5) == 0);
        for (i = 0; i < len; i++) begin
          // A broken message carries stray final flags and lacks its last one.
          if (broken) fin = (i != len - 1) && ($urandom_range(0, 1) == 1);
          else fin = (i == len - 1);
          send_byte(8'($urandom_range(0, 255)), fin, 1'b0, '0);
          sent++;
        end
      end
      steady = 1'b0;
      phase++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pixel_writes_due.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
